// ----- rtl/hpc_pkg.sv -----
// ----------------------------------------------------------------------------
// hpc_pkg
// shared types and constants of the half-plane pixel coverage block
// ----------------------------------------------------------------------------
package hpc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // payload types of the two channels
    typedef logic signed [15:0] t_dist;
    typedef logic [16:0]        t_q16;

    localparam t_q16        ONE_Q16  = 17'd65536;
    localparam logic [14:0] DIST_SAT = 15'd23170;

    // configuration register map
    localparam int          APB_AW          = 2;
    localparam logic [1:0]  REG_ZERO_THRESH = 2'd0;
    localparam t_q16        ZERO_THRESH_RST = 17'd1;

    localparam int DIV_STEPS = 16;

endpackage

// ----- rtl/hpc_if.sv -----
// ----------------------------------------------------------------------------
// hpc_in_if / hpc_out_if
// valid/ready channels carrying a pixel edge sample and its coverage
// ----------------------------------------------------------------------------
interface hpc_in_if
    import hpc_pkg::*;
    ();
    logic  valid;
    logic  ready;
    t_dist distance;
    t_q16  cos_angle;

    modport source (output valid, output distance, output cos_angle, input ready);
    modport sink   (input valid, input distance, input cos_angle, output ready);
endinterface

interface hpc_out_if
    import hpc_pkg::*;
    ();
    logic valid;
    logic ready;
    t_q16 coverage;

    modport source (output valid, output coverage, input ready);
    modport sink   (input valid, input coverage, output ready);
endinterface

// ----- rtl/halfplane_pixel_coverage.sv -----
// ----------------------------------------------------------------------------
// halfplane_pixel_coverage
// area of a unit pixel on the inner side of a line; unless o_cov stalls, one word per cycle
// ----------------------------------------------------------------------------
// i_pix carries a word of signed distance (Q1.15) and cos of the normal angle
// (Q1.16); o_cov returns the covered fraction of the pixel (Q1.16, 65536 is
// full). Both are valid/ready channels; one result word per input word, in
// order. The APB port holds zero_threshold at byte address 0; coverage at or
// below it comes out as zero.
// A word may enter every cycle unless o_cov is stalled. The stages are an
// input stage, the c*c stage, one stage per root bit of the
// square root (FRAC_BITS + 1), the corner distance stage, the multiply stage,
// the dividend stage, sixteen quotient stages of the divider and the output
// register.
// When o_cov is stalled the whole pipeline holds and i_pix.ready drops;
// nothing is lost or repeated. Reset empties the pipeline and sets
// zero_threshold to 1.
// ----------------------------------------------------------------------------
module halfplane_pixel_coverage
    import hpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hpc_in_if.sink            i_pix,
    hpc_out_if.source         o_cov,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW  = FRAC_BITS + 1;      // c, s, dd, root
    localparam int XW  = 2 * FRAC_BITS + 2;  // radicand
    localparam int SQN = FRAC_BITS + 1;      // root bits
    localparam int RW  = FRAC_BITS + 4;      // root remainder
    localparam int PW  = FRAC_BITS + 3;      // signed corner distance
    localparam int QW  = FRAC_BITS + 2;      // positive corner distance
    localparam int NW  = 2 * QW;             // numerator
    localparam int DW  = 2 * FRAC_BITS + 5;  // denominator
    localparam int NDW = NW + DIV_STEPS + 1; // rounded dividend
    localparam int NST = SQN + DIV_STEPS + 6;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    t_q16 r_zt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zt <= ZERO_THRESH_RST;
        end else if (psel && penable && pwrite && paddr == REG_ZERO_THRESH) begin
            r_zt <= pwdata[16:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ZERO_THRESH) ? {15'd0, r_zt} : 32'd0;

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic           w_en;
    logic [NST-1:0] r_vld;

    assign w_en        = !r_vld[NST-1] || o_cov.ready;
    assign i_pix.ready = w_en;
    assign o_cov.valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_pix.valid};
        end
    end

    // ------------------------------------------------------------------
    // input stage: magnitude, saturation, rescale
    // ------------------------------------------------------------------
    logic [16:0]   w_amag;
    logic [14:0]   w_a;
    t_q16          w_cos;
    logic [CW-1:0] n_c, n_dd;
    logic [CW-1:0] r_c0, r_dd0;
    logic          r_neg0;

    always_comb begin
        w_amag = i_pix.distance[15] ? (17'd0 - {i_pix.distance[15], i_pix.distance})
                                    : {1'b0, i_pix.distance};
        w_a    = (w_amag > {2'd0, DIST_SAT}) ? DIST_SAT : w_amag[14:0];
        w_cos  = (i_pix.cos_angle > ONE_Q16) ? ONE_Q16 : i_pix.cos_angle;
    end

    if (FRAC_BITS >= 16) begin : g_c_wide
        assign n_c = CW'(w_cos) << (FRAC_BITS - 16);
    end else begin : g_c_narrow
        assign n_c = CW'((18'(w_cos) + (18'd1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS));
    end

    if (FRAC_BITS >= 15) begin : g_d_wide
        assign n_dd = CW'(w_a) << (FRAC_BITS - 15);
    end else begin : g_d_narrow
        assign n_dd = CW'((16'(w_a) + (16'd1 << (14 - FRAC_BITS))) >> (15 - FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0   <= n_c;
            r_dd0  <= n_dd;
            r_neg0 <= i_pix.distance[15];
        end
    end

    // ------------------------------------------------------------------
    // radicand one - c*c
    // ------------------------------------------------------------------
    logic [XW-1:0] r_x1;
    logic [CW-1:0] r_c1, r_dd1;
    logic          r_neg1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1   <= (XW'(1) << (2 * FRAC_BITS)) - (XW'(r_c0) * XW'(r_c0));
            r_c1   <= r_c0;
            r_dd1  <= r_dd0;
            r_neg1 <= r_neg0;
        end
    end

    // ------------------------------------------------------------------
    // square root, one root bit per stage
    // ------------------------------------------------------------------
    logic [RW-1:0] r_sq_rem  [SQN];
    logic [CW-1:0] r_sq_root [SQN];
    logic [XW-1:0] r_sq_x    [SQN];
    logic [CW-1:0] r_sq_c    [SQN];
    logic [CW-1:0] r_sq_dd   [SQN];
    logic          r_sq_neg  [SQN];

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        logic [RW-1:0] w_rem_in, w_t, w_trial, n_rem;
        logic [CW-1:0] w_root_in, n_root;
        logic [XW-1:0] w_x_in;
        logic [CW-1:0] w_c_in, w_dd_in;
        logic          w_neg_in;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_x_in    = r_x1;
            assign w_c_in    = r_c1;
            assign w_dd_in   = r_dd1;
            assign w_neg_in  = r_neg1;
        end else begin : g_next
            assign w_rem_in  = r_sq_rem[k-1];
            assign w_root_in = r_sq_root[k-1];
            assign w_x_in    = r_sq_x[k-1];
            assign w_c_in    = r_sq_c[k-1];
            assign w_dd_in   = r_sq_dd[k-1];
            assign w_neg_in  = r_sq_neg[k-1];
        end

        always_comb begin
            w_t     = {w_rem_in[RW-3:0], w_x_in[XW-1:XW-2]};
            w_trial = RW'({w_root_in, 2'b01});
            if (w_t >= w_trial) begin
                n_rem  = w_t - w_trial;
                n_root = {w_root_in[CW-2:0], 1'b1};
            end else begin
                n_rem  = w_t;
                n_root = {w_root_in[CW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k]  <= n_rem;
                r_sq_root[k] <= n_root;
                r_sq_x[k]    <= {w_x_in[XW-3:0], 2'b00};
                r_sq_c[k]    <= w_c_in;
                r_sq_dd[k]   <= w_dd_in;
                r_sq_neg[k]  <= w_neg_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // corner distance and case selection
    // ------------------------------------------------------------------
    logic [CW-1:0]        w_s, w_c, w_lo, w_hi;
    logic signed [PW-1:0] w_p;
    logic                 w_zero, w_tri;
    logic [QW-1:0]        r_p2;
    logic [CW-1:0]        r_lo2, r_hi2, r_c2, r_s2;
    logic                 r_tri2, r_zero2, r_neg2;

    always_comb begin
        w_c    = r_sq_c[SQN-1];
        w_s    = r_sq_root[SQN-1] +
                 CW'(r_sq_rem[SQN-1] > RW'(r_sq_root[SQN-1]));
        w_p    = signed'(PW'(w_c) + PW'(w_s) - (PW'(r_sq_dd[SQN-1]) << 1));
        w_lo   = (w_c < w_s) ? w_c : w_s;
        w_hi   = (w_c < w_s) ? w_s : w_c;
        w_zero = w_p[PW-1] || (w_p == '0);
        w_tri  = !w_zero && (PW'(w_p) <= (PW'(w_lo) << 1));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2    <= QW'(w_p);
            r_lo2   <= w_lo;
            r_hi2   <= w_hi;
            r_c2    <= w_c;
            r_s2    <= w_s;
            r_tri2  <= w_tri;
            r_zero2 <= w_zero;
            r_neg2  <= r_sq_neg[SQN-1];
        end
    end

    // ------------------------------------------------------------------
    // numerator and denominator
    // triangle: p*p / (8*c*s), trapezoid: (p - lo) / (2*hi)
    // ------------------------------------------------------------------
    logic [NW-1:0] r_num3;
    logic [DW-1:0] r_den3;
    logic          r_zero3, r_neg3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num3  <= r_tri2 ? (NW'(r_p2) * NW'(r_p2)) : NW'(r_p2 - QW'(r_lo2));
            r_den3  <= r_tri2 ? ((DW'(r_c2) * DW'(r_s2)) << 3) : (DW'(r_hi2) << 1);
            r_zero3 <= r_zero2;
            r_neg3  <= r_neg2;
        end
    end

    // ------------------------------------------------------------------
    // rounded dividend num * 2^16 + den / 2
    // ------------------------------------------------------------------
    logic [NDW-1:0]       w_nd;
    logic [DW:0]          r_rem4;
    logic [DIV_STEPS-1:0] r_low4;
    logic [DW-1:0]        r_den4;
    logic                 r_zero4, r_neg4;

    assign w_nd = (NDW'(r_num3) << DIV_STEPS) + NDW'(r_den3 >> 1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem4  <= (DW + 1)'(w_nd >> DIV_STEPS);
            r_low4  <= w_nd[DIV_STEPS-1:0];
            r_den4  <= r_den3;
            r_zero4 <= r_zero3;
            r_neg4  <= r_neg3;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [DW:0]          r_dv_rem  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_dv_low  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_dv_q    [DIV_STEPS];
    logic [DW-1:0]        r_dv_den  [DIV_STEPS];
    logic                 r_dv_zero [DIV_STEPS];
    logic                 r_dv_neg  [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [DW:0]          w_rem_in, w_t, n_rem;
        logic [DIV_STEPS-1:0] w_low_in, w_q_in;
        logic [DW-1:0]        w_den_in;
        logic                 w_zero_in, w_neg_in, w_bit;

        if (j == 0) begin : g_first
            assign w_rem_in  = r_rem4;
            assign w_low_in  = r_low4;
            assign w_q_in    = '0;
            assign w_den_in  = r_den4;
            assign w_zero_in = r_zero4;
            assign w_neg_in  = r_neg4;
        end else begin : g_next
            assign w_rem_in  = r_dv_rem[j-1];
            assign w_low_in  = r_dv_low[j-1];
            assign w_q_in    = r_dv_q[j-1];
            assign w_den_in  = r_dv_den[j-1];
            assign w_zero_in = r_dv_zero[j-1];
            assign w_neg_in  = r_dv_neg[j-1];
        end

        always_comb begin
            w_t   = {w_rem_in[DW-1:0], w_low_in[DIV_STEPS-1]};
            w_bit = (w_t >= {1'b0, w_den_in});
            n_rem = w_bit ? (w_t - {1'b0, w_den_in}) : w_t;
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[j]  <= n_rem;
                r_dv_low[j]  <= {w_low_in[DIV_STEPS-2:0], 1'b0};
                r_dv_q[j]    <= {w_q_in[DIV_STEPS-2:0], w_bit};
                r_dv_den[j]  <= w_den_in;
                r_dv_zero[j] <= w_zero_in;
                r_dv_neg[j]  <= w_neg_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // sign fold, threshold, output register
    // ------------------------------------------------------------------
    t_q16 w_area, w_cov, r_cov;

    always_comb begin
        w_area = r_dv_zero[DIV_STEPS-1] ? '0 : {1'b0, r_dv_q[DIV_STEPS-1]};
        w_cov  = r_dv_neg[DIV_STEPS-1] ? (ONE_Q16 - w_area) : w_area;
        if (w_cov <= r_zt) begin
            w_cov = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cov <= w_cov;
        end
    end

    assign o_cov.coverage = r_cov;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_cov_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cov.valid |-> (o_cov.coverage <= ONE_Q16))
        else $error("coverage above one");

    a_cov_thresh : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cov.valid && o_cov.coverage != '0) |-> (o_cov.coverage > r_zt))
        else $error("coverage at or below threshold not zeroed");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cov.valid && !o_cov.ready) |-> !i_pix.ready)
        else $error("input taken while pipeline stalled");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_cov.valid)
        else $error("output valid straight after reset");

endmodule

// ----- dv/halfplane_pixel_coverage_tb.sv -----
// ----------------------------------------------------------------------------
// halfplane_pixel_coverage_tb
// drives pixel edge samples with random gaps and output stalls, predicts each
// coverage word in fixed point and compares in order; threshold set per phase
// ----------------------------------------------------------------------------
module halfplane_pixel_coverage_tb
    import hpc_pkg::*;
    ();

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = FB + 23;
    localparam int LIMIT = 400000;

    typedef struct packed {
        t_dist distance;
        t_q16  cos_angle;
        logic  has_fixed;
        t_q16  fixed_cov;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    hpc_in_if  pix_if ();
    hpc_out_if cov_if ();

    halfplane_pixel_coverage uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_if.sink), .o_cov(cov_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    t_q16 cov_expected[$];
    t_q16 thresh;
    int   errors = 0;
    int   cycles = 0;
    bit   sending_done = 0;

    initial begin
        pix_if.valid = 1'b0;
        pix_if.distance = '0;
        pix_if.cos_angle = '0;
        cov_if.ready = 1'b0;
    end

    function automatic longint unsigned root_near(longint unsigned x);
        longint unsigned r, bitv, rem;
        r = 0;
        bitv = 64'd1 << 62;
        rem = x;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= r + bitv) begin
                rem -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        if (x - r * r > r) r++;
        return r;
    endfunction

    function automatic t_q16 predict_coverage(t_dist dist_v, t_q16 cosv, t_q16 thr);
        longint unsigned a, one, c, s, dd, lo, hi, area, p2, den;
        longint p;
        logic [127:0] num;
        bit neg;
        one = 64'd1 << FB;
        neg = dist_v[15];
        a = neg ? (64'h10000 - {48'd0, dist_v}) : {48'd0, dist_v};
        if (a > DIST_SAT) a = DIST_SAT;
        c = (cosv > ONE_Q16) ? ONE_Q16 : cosv;
        s = root_near(one * one - c * c);
        dd = a << 1;
        p = longint'(c + s) - longint'(2 * dd);
        if (p <= 0) begin
            area = 0;
        end else begin
            lo = (c < s) ? c : s;
            hi = (c < s) ? s : c;
            if (unsigned'(p) <= 2 * lo) begin
                p2 = unsigned'(p) * unsigned'(p);
                den = 8 * c * s;
                num = ({64'd0, p2} << 16) + (den >> 1);
                area = 64'(num / den);
            end else begin
                area = (((unsigned'(p) - lo) << 16) + hi) / (2 * hi);
            end
            if (area > ONE_Q16) area = ONE_Q16;
        end
        if (neg) area = ONE_Q16 - area;
        if (area <= thr) area = 0;
        return t_q16'(area);
    endfunction

    task automatic write_threshold(t_q16 value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_ZERO_THRESH; pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        thresh = value;
    endtask

    // words in flight may sit in the pipeline until the queue is empty
    task automatic drain;
        pix_if.valid <= 1'b0;
        wait (cov_expected.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_word(t_dist dist_v, t_q16 cosv, bit has_fixed, t_q16 fixed_cov);
        t_q16 pred;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pred = predict_coverage(dist_v, cosv, thresh);
        if (has_fixed && pred !== fixed_cov)
            $display("%0t predictor disagrees with table: expected %0d got %0d",
                     $time, fixed_cov, pred);
        pix_if.valid <= 1'b1;
        pix_if.distance <= dist_v;
        pix_if.cos_angle <= cosv;
        do @(posedge i_clk); while (!pix_if.ready);
        cov_expected.push_back(has_fixed ? fixed_cov : pred);
    endtask

    // output stalls drawn per word
    initial begin
        int wait_cycles;
        forever begin
            @(posedge i_clk);
            if (cov_if.valid && cov_if.ready) begin
                if (cov_expected.size() == 0) begin
                    $display("%0t unexpected word: expected none got %0d", $time,
                             cov_if.coverage);
                    errors++;
                end else begin
                    t_q16 exp_cov;
                    exp_cov = cov_expected.pop_front();
                    if (cov_if.coverage !== exp_cov) begin
                        $display("%0t coverage mismatch: expected %0d got %0d", $time,
                                 exp_cov, cov_if.coverage);
                        errors++;
                    end
                end
                wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
                if (wait_cycles != 0) begin
                    cov_if.ready <= 1'b0;
                    repeat (wait_cycles) @(posedge i_clk);
                    cov_if.ready <= 1'b1;
                end
            end else if (i_rst_n) begin
                cov_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL halfplane_pixel_coverage");
            $finish;
        end
    end

    t_row directed[] = '{
        '{16'sd0,      17'd65536, 1'b1, 17'd32768},
        '{16'sd0,      17'd0,     1'b1, 17'd32768},
        '{16'sd32767,  17'd65536, 1'b1, 17'd0},
        '{-16'sd32768, 17'd65536, 1'b1, 17'd65536},
        '{16'sd16384,  17'd65536, 1'b1, 17'd0},
        '{-16'sd16384, 17'd0,     1'b1, 17'd65536},
        '{16'sd23170,  17'd46341, 1'b0, 17'd0},
        '{-16'sd23170, 17'd46341, 1'b0, 17'd0},
        '{16'sd8192,   17'd46341, 1'b0, 17'd0},
        '{16'sd8192,   17'd131071, 1'b0, 17'd0},
        '{-16'sd1,     17'd70000, 1'b0, 17'd0},
        '{16'sd1,      17'd1,     1'b0, 17'd0},
        '{16'sd4000,   17'd60000, 1'b0, 17'd0},
        '{16'sd12000,  17'd30000, 1'b0, 17'd0},
        '{-16'sd12000, 17'd30000, 1'b0, 17'd0},
        '{16'sd16383,  17'd65535, 1'b0, 17'd0}
    };

    t_q16 phase_thresh[] = '{17'd0, 17'd65536, 17'd131071, 17'd300, 17'd1};

    initial begin
        t_dist d;
        t_q16 cv;
        thresh = ZERO_THRESH_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k])
            send_word(directed[k].distance, directed[k].cos_angle,
                      directed[k].has_fixed, directed[k].fixed_cov);
        foreach (phase_thresh[ph]) begin
            drain();
            write_threshold(phase_thresh[ph]);
            repeat (390) begin
                case ($urandom_range(0, 5))
                    0: d = t_dist'($urandom);
                    1: d = t_dist'($urandom_range(0, 400)) - 16'sd200;
                    default: d = t_dist'($urandom_range(0, 46340)) - 16'sd23170;
                endcase
                case ($urandom_range(0, 5))
                    0: cv = t_q16'($urandom);
                    1: cv = ($urandom_range(0, 1)) ? 17'd65536 : t_q16'($urandom_range(0, 50));
                    default: cv = t_q16'($urandom_range(0, 65536));
                endcase
                send_word(d, cv, 1'b0, '0);
            end
        end
        sending_done = 1;
        drain();
        if (errors == 0) begin
            $display("PASS halfplane_pixel_coverage");
        end else begin
            $display("FAIL halfplane_pixel_coverage");
        end
        $finish;
    end
endmodule
